/* design/bf3m_pkg.sv */
// Shared constants and types for the mirrored 3x3 box filter.
package bf3m_pkg;

    localparam int DEF_MAX_WIDTH  = 512;
    localparam int DEF_MAX_HEIGHT = 512;

    localparam int PIX_W     = 8;
    localparam int CFG_W     = 10;
    localparam int CFG_IDX_W = 1;
    localparam int CS_W      = 10;
    localparam int SUM_W     = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;
    localparam logic [CFG_W-1:0]     DIM_RESET        = 10'd320;

    localparam int JQ_DEPTH = 4;
    localparam int JQ_LVL_W = $clog2(JQ_DEPTH + 1);

    typedef struct packed {
        logic [CS_W-1:0] cs;
        logic [CS_W-1:0] cs_m;
        logic            use_m;
        logic            k1;
        logic            emit_a;
        logic            emit_b;
        logic            eof_b;
    } t_job;

    typedef struct packed {
        logic [JQ_LVL_W-1:0] level;
        logic                nonempty;
        logic                full;
    } t_qstat;

endpackage

/* design/bf3m_ram.sv */
// Generic RAM: one write port, two read ports with registered read data.
module bf3m_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1536,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

/* design/bf3m_front.sv */
// Front end: pixel transfer, raster counters, line store and column-sum jobs.
module bf3m_front #(
    parameter int MAX_WIDTH  = bf3m_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bf3m_pkg::DEF_MAX_HEIGHT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [bf3m_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bf3m_pkg::CFG_W-1:0]       i_cfg_wdata,
    input  logic                             i_pixel_valid,
    output logic                             o_pixel_ready,
    input  logic [bf3m_pkg::PIX_W-1:0]       i_pixel_in,
    input  bf3m_pkg::t_qstat                 i_qstat,
    output logic                             o_push,
    output bf3m_pkg::t_job                   o_job
);

    import bf3m_pkg::*;

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int DWW   = (WW > CFG_W) ? WW : CFG_W;
    localparam int DHW   = (HW > CFG_W) ? HW : CFG_W;
    localparam int DEPTH = 3 * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);

    logic [CFG_W-1:0] r_reg_width;
    logic [CFG_W-1:0] r_reg_height;
    logic [CW-1:0]    r_col;
    logic [RW-1:0]    r_row;
    logic [1:0]       r_slot;
    logic [WW-1:0]    r_frame_w;
    logic [HW-1:0]    r_frame_h;
    logic             r_pending;
    logic [WW-1:0]    r_pend_w;

    logic             r_s1_valid;
    logic [PIX_W-1:0] r_s1_pix;
    logic             r_s1_top_pix;
    logic             r_s1_pend;
    logic             r_s1_cap;
    logic             r_s1_k1;
    logic             r_s1_use_m;
    logic             r_s1_emit_a;
    logic             r_s1_emit_b;
    logic [CS_W-1:0]  r_pend_cs0;

    logic              accept;
    logic [JQ_LVL_W:0] room_need;
    logic [DWW-1:0]    rw_ext;
    logic [DHW-1:0]    rh_ext;
    logic [WW-1:0]     clamp_w;
    logic [HW-1:0]     clamp_h;
    logic              first;
    logic [WW-1:0]     cur_w;
    logic [HW-1:0]     cur_h;
    logic [WW-1:0]     col_ext;
    logic [HW-1:0]     row_ext;
    logic              last_col;
    logic              last_row;
    logic              in_main;
    logic              pend_act;
    logic              pend_end;
    logic [CW-1:0]     rd_col;
    logic [1:0]        slot_prev;
    logic [1:0]        slot_prev2;
    logic [AW-1:0]     waddr;
    logic [AW-1:0]     raddr_a;
    logic [AW-1:0]     raddr_b;
    logic [PIX_W-1:0]  ram_a;
    logic [PIX_W-1:0]  ram_b;
    logic [PIX_W-1:0]  cs_top;
    logic [PIX_W-1:0]  cs_bot;
    logic [CS_W-1:0]   cs;

    function automatic logic [AW-1:0] slot_base(input logic [1:0] s);
        logic [AW-1:0] b;
        case (s)
            2'd0: b = '0;
            2'd1: b = AW'(MAX_WIDTH);
            default: b = AW'(2 * MAX_WIDTH);
        endcase
        return b;
    endfunction

    assign accept        = i_pixel_valid && o_pixel_ready;
    assign room_need     = {1'b0, i_qstat.level} + {{JQ_LVL_W{1'b0}}, r_s1_valid};
    assign o_pixel_ready = room_need < (JQ_LVL_W + 1)'(JQ_DEPTH);

    assign rw_ext  = DWW'(r_reg_width);
    assign rh_ext  = DHW'(r_reg_height);
    assign clamp_w = (rw_ext < DWW'(3)) ? WW'(3) :
                     (rw_ext > DWW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(rw_ext);
    assign clamp_h = (rh_ext < DHW'(3)) ? HW'(3) :
                     (rh_ext > DHW'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(rh_ext);

    assign first    = (r_row == '0) && (r_col == '0);
    assign cur_w    = first ? clamp_w : r_frame_w;
    assign cur_h    = first ? clamp_h : r_frame_h;
    assign col_ext  = WW'(r_col);
    assign row_ext  = HW'(r_row);
    assign last_col = (col_ext + WW'(1)) >= cur_w;
    assign last_row = (row_ext + HW'(1)) >= cur_h;
    assign in_main  = (r_row != '0);
    assign pend_act = !in_main && r_pending;
    assign pend_end = pend_act && ((col_ext + WW'(2)) == r_pend_w);

    // look one column ahead while finishing the previous frame's last row
    assign rd_col     = pend_act ? (r_col + CW'(1)) : r_col;
    assign slot_prev  = (r_slot == 2'd0) ? 2'd2 : (r_slot - 2'd1);
    assign slot_prev2 = (r_slot == 2'd2) ? 2'd0 : (r_slot + 2'd1);
    assign waddr      = slot_base(r_slot) + AW'(r_col);
    assign raddr_a    = slot_base(slot_prev2) + AW'(rd_col);
    assign raddr_b    = slot_base(slot_prev) + AW'(rd_col);

    bf3m_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (accept),
        .i_waddr   (waddr),
        .i_wdata   (i_pixel_in),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (ram_a),
        .o_rdata_b (ram_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reg_width  <= DIM_RESET;
            r_reg_height <= DIM_RESET;
            r_col        <= '0;
            r_row        <= '0;
            r_slot       <= 2'd0;
            r_pending    <= 1'b0;
            r_s1_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_LINE_WIDTH:   r_reg_width  <= i_cfg_wdata;
                    CFG_FRAME_HEIGHT: r_reg_height <= i_cfg_wdata;
                    default: ;
                endcase
            end
            r_s1_valid <= accept;
            if (accept) begin
                if (last_col && last_row) begin
                    r_pending <= 1'b1;
                end else if (pend_end || (last_col && !in_main)) begin
                    r_pending <= 1'b0;
                end
                if (last_col) begin
                    r_col  <= '0;
                    r_slot <= slot_prev2;
                    if (last_row) begin
                        r_row <= '0;
                    end else begin
                        r_row <= r_row + RW'(1);
                    end
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (first) begin
                r_frame_w <= clamp_w;
                r_frame_h <= clamp_h;
            end
            if (last_col && last_row) begin
                r_pend_w <= cur_w;
            end
            r_s1_pix     <= i_pixel_in;
            r_s1_top_pix <= (r_row == RW'(1));
            r_s1_pend    <= pend_act;
            r_s1_cap     <= in_main && last_row && (r_col == '0);
            r_s1_k1      <= in_main ? (r_col == CW'(1)) : (r_col == '0);
            r_s1_use_m   <= pend_act && (r_col == '0);
            r_s1_emit_a  <= in_main ? (r_col != '0) : pend_act;
            r_s1_emit_b  <= in_main ? last_col : pend_end;
        end
        // hold column 0 of the two bottom rows for the mirrored last row
        if (r_s1_valid && r_s1_cap) begin
            r_pend_cs0 <= CS_W'(ram_b) + CS_W'(ram_b) + CS_W'(r_s1_pix);
        end
    end

    assign cs_top = r_s1_pend ? ram_a : (r_s1_top_pix ? r_s1_pix : ram_a);
    assign cs_bot = r_s1_pend ? ram_a : r_s1_pix;
    assign cs     = CS_W'(cs_top) + CS_W'(ram_b) + CS_W'(cs_bot);

    assign o_push       = r_s1_valid;
    assign o_job.cs     = cs;
    assign o_job.cs_m   = r_pend_cs0;
    assign o_job.use_m  = r_s1_use_m;
    assign o_job.k1     = r_s1_k1;
    assign o_job.emit_a = r_s1_emit_a;
    assign o_job.emit_b = r_s1_emit_b;
    assign o_job.eof_b  = r_s1_pend;

endmodule

/* design/bf3m_queue.sv */
// Job queue between the front end and the back end.
module bf3m_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  bf3m_pkg::t_job   i_job,
    input  logic             i_pop,
    output bf3m_pkg::t_job   o_head,
    output bf3m_pkg::t_qstat o_stat
);

    import bf3m_pkg::*;

    localparam int PW = $clog2(JQ_DEPTH);

    t_job                r_mem [JQ_DEPTH];
    logic [PW-1:0]       r_wp;
    logic [PW-1:0]       r_rp;
    logic [JQ_LVL_W-1:0] r_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_level <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + PW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + PW'(1);
            end
            r_level <= r_level + JQ_LVL_W'(i_push) - JQ_LVL_W'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    assign o_head          = r_mem[r_rp];
    assign o_stat.level    = r_level;
    assign o_stat.nonempty = (r_level != '0);
    assign o_stat.full     = (r_level == JQ_LVL_W'(JQ_DEPTH));

endmodule

/* design/bf3m_back.sv */
// Back end: 3x3 window from column sums, divide by nine, result register.
module bf3m_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  bf3m_pkg::t_job             i_head,
    input  bf3m_pkg::t_qstat           i_qstat,
    output logic                       o_pop,
    output logic                       o_result_valid,
    input  logic                       i_result_ready,
    output logic [bf3m_pkg::PIX_W-1:0] o_pixel_out,
    output logic                       o_end_of_line,
    output logic                       o_end_of_frame
);

    import bf3m_pkg::*;

    localparam int                RCP_W   = 13;
    localparam logic [RCP_W-1:0]  RECIP_9 = 13'd7282;
    localparam int                RCP_SH  = 16;

    logic [CS_W-1:0]  r_cs1;
    logic [CS_W-1:0]  r_cs2;
    logic             r_phase;
    logic             r_a_valid;
    logic [SUM_W-1:0] r_a_sum;
    logic             r_a_eol;
    logic             r_a_eof;
    logic             r_out_valid;
    logic [PIX_W-1:0] r_out_pix;
    logic             r_out_eol;
    logic             r_out_eof;

    logic             en;
    logic             have;
    logic [CS_W-1:0]  mid_eff;
    logic [CS_W-1:0]  left;
    logic [SUM_W-1:0] sum_a;
    logic [SUM_W-1:0] sum_b;
    logic             do_a;
    logic             do_b;

    function automatic logic [PIX_W-1:0] div9(input logic [SUM_W-1:0] s);
        logic [SUM_W+RCP_W-1:0] p;
        p = {{RCP_W{1'b0}}, s} * {{SUM_W{1'b0}}, RECIP_9};
        return p[RCP_SH +: PIX_W];
    endfunction

    assign en      = !r_out_valid || i_result_ready;
    assign have    = i_qstat.nonempty;
    assign mid_eff = i_head.use_m ? i_head.cs_m : r_cs1;
    assign left    = i_head.k1 ? i_head.cs : r_cs2;
    assign sum_a   = SUM_W'(left) + SUM_W'(mid_eff) + SUM_W'(i_head.cs);
    assign sum_b   = SUM_W'(mid_eff) + SUM_W'(mid_eff) + SUM_W'(i_head.cs);
    assign do_a    = have && i_head.emit_a && !r_phase;
    assign do_b    = have && i_head.emit_b && !do_a;
    assign o_pop   = en && have && !(do_a && i_head.emit_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= 1'b0;
            r_a_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_a_valid   <= do_a || do_b;
            r_out_valid <= r_a_valid;
            if (have) begin
                r_phase <= do_a && i_head.emit_b;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_sum   <= do_a ? sum_a : sum_b;
            r_a_eol   <= do_b;
            r_a_eof   <= do_b && i_head.eof_b;
            r_out_pix <= div9(r_a_sum);
            r_out_eol <= r_a_eol;
            r_out_eof <= r_a_eof;
        end
        if (o_pop) begin
            r_cs2 <= mid_eff;
            r_cs1 <= i_head.cs;
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_pixel_out    = r_out_pix;
    assign o_end_of_line  = r_out_eol;
    assign o_end_of_frame = r_out_eof;

endmodule

/* design/box_filter_3x3_mirror.sv */
// Top level of the mirrored 3x3 box filter.
// Takes 8-bit pixels in raster order and gives the truncated mean of each pixel's mirrored
// 3x3 neighborhood, with end-of-line and end-of-frame marks. A pixel transfer is taken every
// cycle while the four-entry job queue has room. The back end takes the jobs in order and
// spends an extra step on the right-edge result of a row, so it falls behind a full-rate
// input over a long stream; the queue covers the gap over short bursts. A result passes
// through the registered line-store read, the job queue, the window adder and the
// divide-by-nine multiplier before it is offered; the right-edge result of a row comes from
// the same job as the result before it. The result for row r appears as row r+1 streams in,
// and the last row of a frame appears only while row 0 of the next frame streams in.
// line_width and frame_height are clamped to 3..MAX and latched on the first pixel of a
// frame. The line store needs no clearing after reset.
module box_filter_3x3_mirror #(
    parameter int MAX_WIDTH  = bf3m_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bf3m_pkg::DEF_MAX_HEIGHT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bf3m_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bf3m_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  logic                           i_pixel_valid,
    output logic                           o_pixel_ready,
    input  logic [bf3m_pkg::PIX_W-1:0]     i_pixel_in,
    output logic                           o_result_valid,
    input  logic                           i_result_ready,
    output logic [bf3m_pkg::PIX_W-1:0]     o_pixel_out,
    output logic                           o_end_of_line,
    output logic                           o_end_of_frame
);

    import bf3m_pkg::*;

    logic   q_push;
    t_job   q_in;
    logic   q_pop;
    t_job   q_head;
    t_qstat q_stat;

    bf3m_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_pixel_valid (i_pixel_valid),
        .o_pixel_ready (o_pixel_ready),
        .i_pixel_in    (i_pixel_in),
        .i_qstat       (q_stat),
        .o_push        (q_push),
        .o_job         (q_in)
    );

    bf3m_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_stat  (q_stat)
    );

    bf3m_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (q_head),
        .i_qstat        (q_stat),
        .o_pop          (q_pop),
        .o_result_valid (o_result_valid),
        .i_result_ready (i_result_ready),
        .o_pixel_out    (o_pixel_out),
        .o_end_of_line  (o_end_of_line),
        .o_end_of_frame (o_end_of_frame)
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_push && q_stat.full))
        else $error("job pushed into full queue");

    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.level <= JQ_LVL_W'(JQ_DEPTH))
        else $error("queue level out of range");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_stat.nonempty)
        else $error("job popped from empty queue");

    a_eof_eol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_end_of_frame) |-> o_end_of_line)
        else $error("end of frame without end of line");

endmodule

/* tb/box_filter_3x3_mirror_tb.sv */
// Self-checking testbench for the mirrored 3x3 box filter: pixel frames against a built-in model.
module box_filter_3x3_mirror_tb;
    import bf3m_pkg::*;

    localparam int MAX_W         = DEF_MAX_WIDTH;
    localparam int MAX_H         = DEF_MAX_HEIGHT;
    localparam int IDLE_LIMIT    = 1000;
    localparam int SETTLE        = 12;
    localparam int RANDOM_PIXELS = 40;
    localparam int REPORT_MAX    = 10;

    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic             eol;
        logic             eof;
    } t_mean;

    typedef enum {FILL_RANDOM, FILL_WHITE, FILL_BLACK} t_fill;

    class mean_tracker;
        logic [PIX_W-1:0] rows [3*MAX_W];
        int unsigned row_cnt, col_cnt, slot;
        int unsigned reg_w, reg_h, fw, fh;
        int unsigned tail_w, tail_col;
        bit          tail_open;
        t_mean       means_due[$];
        int unsigned pixels, frames, compared, errors;

        function new();
            row_cnt   = 0;
            col_cnt   = 0;
            slot      = 0;
            reg_w     = DIM_RESET;
            reg_h     = DIM_RESET;
            fw        = DIM_RESET;
            fh        = DIM_RESET;
            tail_w    = 3;
            tail_col  = 0;
            tail_open = 1'b0;
            pixels    = 0;
            frames    = 0;
            compared  = 0;
            errors    = 0;
        endfunction

        function int unsigned clamp_dim(int unsigned v, int unsigned maxv);
            if (v < 3) return 3;
            if (v > maxv) return maxv;
            return v;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            if (idx == CFG_LINE_WIDTH) reg_w = val;
            else reg_h = val;
        endfunction

        function int unsigned frame_len();
            return clamp_dim(reg_w, MAX_W) * clamp_dim(reg_h, MAX_H);
        endfunction

        function logic [PIX_W-1:0] window_mean(int unsigned up, int unsigned mid,
                                                int unsigned dn, int unsigned oc,
                                                int unsigned w);
            int unsigned sl[3];
            int unsigned cl[3];
            int unsigned sum;
            sl[0] = up;
            sl[1] = mid;
            sl[2] = dn;
            cl[0] = (oc == 0) ? 1 : oc - 1;
            cl[1] = oc;
            cl[2] = (oc + 1 >= w) ? w - 2 : oc + 1;
            sum = 0;
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    sum += rows[(sl[i] % 3) * MAX_W + (cl[j] % MAX_W)];
            return PIX_W'(sum / 9);
        endfunction

        function void add_due(logic [PIX_W-1:0] pix, logic eol, logic eof);
            t_mean m;
            m.pix = pix;
            m.eol = eol;
            m.eof = eof;
            means_due.push_back(m);
        endfunction

        function void take_pixel(logic [PIX_W-1:0] px);
            int unsigned r, c, prv, prv2, up;
            if (row_cnt == 0 && col_cnt == 0) begin
                fw = clamp_dim(reg_w, MAX_W);
                fh = clamp_dim(reg_h, MAX_H);
            end
            r = row_cnt;
            c = col_cnt;
            rows[slot * MAX_W + (c % MAX_W)] = px;
            prv  = (slot + 2) % 3;
            prv2 = (slot + 1) % 3;
            pixels++;

            // last row of the previous frame: rows above and below both read row H-2
            if (r == 0 && tail_open) begin
                add_due(window_mean(prv2, prv, prv2, tail_col, tail_w), 1'b0, 1'b0);
                tail_col++;
                if (tail_col == tail_w - 1) begin
                    add_due(window_mean(prv2, prv, prv2, tail_col, tail_w), 1'b1, 1'b1);
                    tail_col++;
                end
                if (tail_col >= tail_w) tail_open = 1'b0;
            end

            if (r >= 1) begin
                up = (r == 1) ? slot : prv2;
                if (c >= 1) add_due(window_mean(up, prv, slot, c - 1, fw), 1'b0, 1'b0);
                if (c == fw - 1) add_due(window_mean(up, prv, slot, c, fw), 1'b1, 1'b0);
            end

            if (c + 1 >= fw) begin
                col_cnt = 0;
                if (r == 0) tail_open = 1'b0;
                slot = (slot + 1) % 3;
                if (r + 1 >= fh) begin
                    row_cnt   = 0;
                    tail_open = 1'b1;
                    tail_w    = fw;
                    tail_col  = 0;
                    frames++;
                end else begin
                    row_cnt = r + 1;
                end
            end else begin
                col_cnt = c + 1;
            end
        endfunction

        function void compare_mean(t_mean got);
            t_mean want;
            if (means_due.size() == 0) begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("Unexpected result: pixel %0d eol %0b eof %0b",
                             got.pix, got.eol, got.eof);
                return;
            end
            want = means_due.pop_front();
            compared++;
            if (got.pix !== want.pix || got.eol !== want.eol || got.eof !== want.eof) begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("Mismatch %0d: expected %0d/%0b/%0b, got %0d/%0b/%0b",
                             compared, want.pix, want.eol, want.eof,
                             got.pix, got.eol, got.eof);
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_wdata;
    logic                 i_pixel_valid;
    logic                 o_pixel_ready;
    logic [PIX_W-1:0]     i_pixel_in;
    logic                 o_result_valid;
    logic                 i_result_ready;
    logic [PIX_W-1:0]     o_pixel_out;
    logic                 o_end_of_line;
    logic                 o_end_of_frame;

    mean_tracker tracker;
    bit          send_gaps;
    bit          recv_stalls;
    bit          moved;
    int unsigned stall_left  = 0;
    int unsigned idle_cycles = 0;
    int unsigned shapes      = 0;
    t_mean       got;

    box_filter_3x3_mirror DUT (.*);

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left--;
            i_result_ready <= 1'b0;
        end else if (recv_stalls && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 4);
            i_result_ready <= 1'b0;
        end else begin
            i_result_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        moved = 1'b0;
        if (i_rst_n && i_pixel_valid && o_pixel_ready) begin
            tracker.take_pixel(i_pixel_in);
            moved = 1'b1;
        end
        if (i_rst_n && o_result_valid && i_result_ready) begin
            got.pix = o_pixel_out;
            got.eol = o_end_of_line;
            got.eof = o_end_of_frame;
            tracker.compare_mean(got);
            moved = 1'b1;
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    function automatic logic [PIX_W-1:0] pick_pixel(t_fill fill);
        case (fill)
            FILL_WHITE: return '1;
            FILL_BLACK: return '0;
            default: begin
                case ($urandom_range(0, 7))
                    0:       return '0;
                    1:       return '1;
                    default: return PIX_W'($urandom_range(0, 255));
                endcase
            end
        endcase
    endfunction

    task automatic pick_idle();
        int unsigned m;
        m = $urandom_range(0, 3);
        send_gaps   = m[0];
        recv_stalls = m[1];
    endtask

    task automatic send_pixel(input logic [PIX_W-1:0] px);
        if (send_gaps && $urandom_range(0, 5) == 0) begin
            i_pixel_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_pixel_valid <= 1'b1;
        i_pixel_in    <= px;
        do @(posedge i_clk); while (!o_pixel_ready);
    endtask

    task automatic run_shape(input int unsigned w, input int unsigned h, input bit wr_w,
                             input bit wr_h, input int unsigned nframes, input t_fill fill);
        int unsigned total;
        do @(posedge i_clk); while (tracker.means_due.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
        if (wr_w) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= CFG_LINE_WIDTH;
            i_cfg_wdata <= CFG_W'(w);
            tracker.set_reg(CFG_LINE_WIDTH, CFG_W'(w));
            @(posedge i_clk);
        end
        if (wr_h) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= CFG_FRAME_HEIGHT;
            i_cfg_wdata <= CFG_W'(h);
            tracker.set_reg(CFG_FRAME_HEIGHT, CFG_W'(h));
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        total = tracker.frame_len() * nframes;
        repeat (total) send_pixel(pick_pixel(fill));
        i_pixel_valid <= 1'b0;
        shapes++;
    endtask

    initial begin
        int unsigned rnd_start, w, h, m;
        tracker        = new();
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = CFG_LINE_WIDTH;
        i_cfg_wdata    = '0;
        i_pixel_valid  = 1'b0;
        i_pixel_in     = '0;
        i_result_ready = 1'b0;
        send_gaps      = 1'b0;
        recv_stalls    = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // below-minimum register values act as a 3x3 frame
        run_shape(0, 2, 1'b1, 1'b1, 1, FILL_WHITE);
        run_shape(0, 2, 1'b0, 1'b0, 1, FILL_BLACK);

        // narrower then wider frame while the previous last row drains
        pick_idle();
        run_shape(12, 3, 1'b1, 1'b1, 1, FILL_RANDOM);
        pick_idle();
        run_shape(3, 4, 1'b1, 1'b1, 1, FILL_RANDOM);
        pick_idle();
        run_shape(9, 3, 1'b1, 1'b1, 1, FILL_RANDOM);

        rnd_start = tracker.pixels;
        while (tracker.pixels - rnd_start < RANDOM_PIXELS) begin
            pick_idle();
            w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
            h = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 6);
            m = $urandom_range(1, 3);
            run_shape(w, h, m[0], m[1], $urandom_range(1, 2), FILL_RANDOM);
        end

        send_gaps   = 1'b0;
        recv_stalls = 1'b0;
        run_shape(7, 4, 1'b1, 1'b1, 2, FILL_RANDOM);
        run_shape(5, 3, 1'b1, 1'b1, 1, FILL_RANDOM);

        do @(posedge i_clk); while (tracker.means_due.size() != 0);
        repeat (SETTLE) @(posedge i_clk);

        $display("Covered %0d pixels in %0d frames over %0d shapes, register sides 0 to 12.",
                 tracker.pixels, tracker.frames, shapes);
        $display("%0d results compared, %0d errors, %0d results still due.",
                 tracker.compared, tracker.errors, tracker.means_due.size());
        if (tracker.errors == 0 && tracker.means_due.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
